// ----- rtl/core/bilinear_upscale_with_fraction_core_defines.svh -----
// Assertion macros for the bilinear upscaler core and its checker.
// Expects clk_i and rst_ni to be visible where a macro is used.
`ifndef BILINEAR_UPSCALE_WITH_FRACTION_CORE_DEFINES_SVH
`define BILINEAR_UPSCALE_WITH_FRACTION_CORE_DEFINES_SVH

// Checked only outside reset.
`define BUFC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked at every edge, reset included.
`define BUFC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

// ----- rtl/core/bufc_pkg.sv -----
// bufc_pkg: sizes, codes, types and the pixel address helper of the upscaler.
// No dependencies.
`default_nettype none

package bufc_pkg;

  // Image store geometry
  localparam int MAX_WIDTH    = 64;
  localparam int MAX_HEIGHT   = 64;
  localparam int CHANNEL_BITS = 8;
  localparam int DEPTH        = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W       = $clog2(DEPTH);

  // Field widths
  localparam int PIX_W   = 32;
  localparam int CH_W    = 8;
  localparam int NUM_CH  = 4;
  localparam int POS_W   = 9;
  localparam int HI_W    = 10;  // pos + half scale, before the shift
  localparam int SIZE_W  = 7;
  localparam int SHIFT_W = 2;
  localparam int SCALE_W = 4;   // 2^shift, up to 8
  localparam int WGT_W   = 7;   // product of two axis weights, up to 64
  localparam int SUM_W   = 14;  // 255 * 64 fits
  localparam int FRAC_W  = 6;
  localparam int NUM_NB  = 4;
  localparam int NB_W    = 2;
  localparam int MOD_CNT_W = $clog2(HI_W + 1);

  // Register port
  localparam int PADDR_W   = 5;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = 3;

  localparam logic [CH_W-1:0] CH_MASK = CH_W'((1 << CHANNEL_BITS) - 1);
  localparam logic [SIZE_W-1:0] W_LIMIT = SIZE_W'((MAX_WIDTH < 127) ? MAX_WIDTH : 127);
  localparam logic [SIZE_W-1:0] H_LIMIT = SIZE_W'((MAX_HEIGHT < 127) ? MAX_HEIGHT : 127);

  localparam logic OP_STORE   = 1'b0;
  localparam logic OP_QUERY   = 1'b1;
  localparam logic EDGE_WRAP  = 1'b0;
  localparam logic EDGE_CLAMP = 1'b1;

  localparam logic [REG_IDX_W-1:0] REG_X_SHIFT    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_Y_SHIFT    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_EDGE_MODE  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd4;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [PIX_W-1:0]  pix_t;
  typedef logic [HI_W-1:0]   idx_t;
  typedef logic [SIZE_W-1:0] size_t;
  typedef logic [WGT_W-1:0]  wgt_t;
  typedef logic [SUM_W-1:0]  sum_t;
  typedef sum_t [NUM_CH-1:0] sum_vec_t;

  typedef struct packed {
    logic en;
    logic first;
  } mac_ctl_t;

  // Row-major address: row * MAX_WIDTH + column
  function automatic addr_t pix_addr(input idx_t x, input idx_t y);
    return ADDR_W'(32'(y) * MAX_WIDTH + 32'(x));
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/bufc_ram.sv -----
// bufc_ram: generic single-port RAM, one write or one read per cycle.
// Registered read data. No dependencies.
`default_nettype none

module bufc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/core/bufc_mod.sv -----
// bufc_mod: restoring remainder unit, one quotient bit per cycle.
// Depends on bufc_pkg.
`default_nettype none

module bufc_mod (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  bufc_pkg::idx_t   dividend_i,
  input  bufc_pkg::size_t  divisor_i,
  output logic             done_o,
  output bufc_pkg::size_t  rem_o
);
  import bufc_pkg::*;

  logic                 busy_q, busy_d;
  logic [MOD_CNT_W-1:0] cnt_q, cnt_d;
  idx_t                 dvd_q;
  size_t                dvs_q;
  size_t                rem_q;
  logic [SIZE_W:0]      trial;
  logic                 step;

  assign done_o = busy_q && (cnt_q == MOD_CNT_W'(HI_W));
  assign step   = busy_q && !done_o;
  assign trial  = {rem_q, dvd_q[HI_W-1]};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (done_o) begin
      busy_d = 1'b0;
    end else if (step) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (step) begin
      dvd_q <= {dvd_q[HI_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs_q}) begin
        rem_q <= SIZE_W'(trial - {1'b0, dvs_q});
      end else begin
        rem_q <= trial[SIZE_W-1:0];
      end
    end
  end

  assign rem_o = rem_q;

endmodule

`default_nettype wire

// ----- rtl/core/bufc_mac.sv -----
// bufc_mac: weighted accumulator, one lane per color channel.
// Depends on bufc_pkg.
`default_nettype none

module bufc_mac (
  input  logic               clk_i,
  input  bufc_pkg::mac_ctl_t ctl_i,
  input  bufc_pkg::pix_t     pix_i,
  input  bufc_pkg::wgt_t     wgt_i,
  output bufc_pkg::sum_vec_t acc_o
);
  import bufc_pkg::*;

  sum_vec_t acc_q, acc_d;
  logic [CH_W+WGT_W-1:0] prod [NUM_CH];

  always_comb begin
    acc_d = acc_q;
    for (int c = 0; c < NUM_CH; c++) begin
      prod[c] = (CH_W+WGT_W)'(pix_i[c*CH_W +: CH_W]) * (CH_W+WGT_W)'(wgt_i);
      if (ctl_i.en) begin
        acc_d[c] = SUM_W'(prod[c]) + (ctl_i.first ? '0 : acc_q[c]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire

// ----- rtl/core/bilinear_upscale_with_fraction_core.sv -----
// bilinear_upscale_with_fraction_core: power-of-two bilinear upscaler with fraction out.
// Uses bufc_pkg, bufc_ram, bufc_mod and bufc_mac.
// Store beat: no result. Query beat: result loaded into the output register once any earlier
// result is taken; no new beat is accepted until then. Its path: the shared remainder unit
// (10 steps per axis), then 4 reads on the single pixel RAM port, then the MAC drain.
// Reset: config to defaults, sequencer idle, no result pending; pixel RAM not cleared.
`default_nettype none

module bilinear_upscale_with_fraction_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bufc_pkg::PADDR_W-1:0]  paddr,
  input  logic [bufc_pkg::PDATA_W-1:0]  pwdata,
  output logic [bufc_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          opcode_i,
  input  logic [bufc_pkg::POS_W-1:0]    pos_x_i,
  input  logic [bufc_pkg::POS_W-1:0]    pos_y_i,
  input  logic [bufc_pkg::CH_W-1:0]     red_in_i,
  input  logic [bufc_pkg::CH_W-1:0]     green_in_i,
  input  logic [bufc_pkg::CH_W-1:0]     blue_in_i,
  input  logic [bufc_pkg::CH_W-1:0]     alpha_in_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bufc_pkg::CH_W-1:0]     red_out_o,
  output logic [bufc_pkg::CH_W-1:0]     green_out_o,
  output logic [bufc_pkg::CH_W-1:0]     blue_out_o,
  output logic [bufc_pkg::CH_W-1:0]     alpha_out_o,
  output logic [bufc_pkg::FRAC_W-1:0]   red_frac_o,
  output logic [bufc_pkg::FRAC_W-1:0]   green_frac_o,
  output logic [bufc_pkg::FRAC_W-1:0]   blue_frac_o,
  output logic [bufc_pkg::FRAC_W-1:0]   alpha_frac_o
);
  import bufc_pkg::*;

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MODX  = 3'd1;  // column remainder in flight
  localparam logic [2:0] S_MODY  = 3'd2;  // row remainder in flight
  localparam logic [2:0] S_RD    = 3'd3;  // four neighbour reads
  localparam logic [2:0] S_DRAIN = 3'd4;  // last read data into the MAC
  localparam logic [2:0] S_OUT   = 3'd5;  // hand result to output register

  localparam logic [NB_W-1:0] LAST_NB = NB_W'(NUM_NB - 1);

  localparam logic [SHIFT_W-1:0] X_SHIFT_RST = 2'd2;
  localparam logic [SHIFT_W-1:0] Y_SHIFT_RST = 2'd2;
  localparam logic [SIZE_W-1:0]  WIDTH_RST   = 7'd64;
  localparam logic [SIZE_W-1:0]  HEIGHT_RST  = 7'd64;

  typedef struct packed {
    idx_t lo;
    idx_t hi;
  } idx_pair_t;

  // Neighbour pair for one axis. Wrap uses the remainder hi % size;
  // the lower neighbour is one below it, or size-1 when it is zero.
  function automatic idx_pair_t axis_idx(input idx_t hi, input size_t rem,
                                         input size_t size, input logic clamp);
    idx_pair_t r;
    idx_t      sz;
    idx_t      top_i;
    idx_t      hm1;
    sz    = HI_W'(size);
    top_i = sz - 1'b1;
    hm1   = hi - 1'b1;
    if (!clamp) begin
      r.hi = HI_W'(rem);
      r.lo = (rem == '0) ? top_i : HI_W'(rem) - 1'b1;
    end else begin
      r.hi = (hi >= sz) ? top_i : hi;
      r.lo = (hi == '0) ? '0 : ((hm1 >= sz) ? top_i : hm1);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [SHIFT_W-1:0]   x_shift_q, y_shift_q;
  logic                 edge_mode_q;
  size_t                width_q, height_q;
  logic                 cfg_we;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign reg_idx = paddr[PADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_shift_q   <= X_SHIFT_RST;
      y_shift_q   <= Y_SHIFT_RST;
      edge_mode_q <= EDGE_WRAP;
      width_q     <= WIDTH_RST;
      height_q    <= HEIGHT_RST;
    end else if (cfg_we) begin
      case (reg_idx)
        REG_X_SHIFT:    x_shift_q   <= pwdata[SHIFT_W-1:0];
        REG_Y_SHIFT:    y_shift_q   <= pwdata[SHIFT_W-1:0];
        REG_EDGE_MODE:  edge_mode_q <= pwdata[0];
        REG_SRC_WIDTH:  width_q     <= pwdata[SIZE_W-1:0];
        REG_SRC_HEIGHT: height_q    <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_X_SHIFT:    prdata = PDATA_W'(x_shift_q);
      REG_Y_SHIFT:    prdata = PDATA_W'(y_shift_q);
      REG_EDGE_MODE:  prdata = PDATA_W'(edge_mode_q);
      REG_SRC_WIDTH:  prdata = PDATA_W'(width_q);
      REG_SRC_HEIGHT: prdata = PDATA_W'(height_q);
      default:        prdata = '0;
    endcase
  end

  // Effective image size: zero acts as one, above the store acts as max
  size_t w_eff, h_eff;
  assign w_eff = (width_q == '0) ? SIZE_W'(1) : ((width_q > W_LIMIT) ? W_LIMIT : width_q);
  assign h_eff = (height_q == '0) ? SIZE_W'(1) : ((height_q > H_LIMIT) ? H_LIMIT : height_q);

  // ---------------------------------------------------------------------
  // Input handshake, store path
  // ---------------------------------------------------------------------
  logic [2:0] state_q, state_d;
  logic       in_acc, store_acc, query_acc, store_ok;
  addr_t      st_addr;
  pix_t       st_data;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign store_ok   = (HI_W'(pos_x_i) < HI_W'(w_eff)) && (HI_W'(pos_y_i) < HI_W'(h_eff));
  assign store_acc  = in_acc && (opcode_i == OP_STORE) && store_ok;
  assign query_acc  = in_acc && (opcode_i == OP_QUERY);
  assign st_addr    = pix_addr(HI_W'(pos_x_i), HI_W'(pos_y_i));
  assign st_data    = {alpha_in_i & CH_MASK, blue_in_i & CH_MASK,
                       green_in_i & CH_MASK, red_in_i & CH_MASK};

  // ---------------------------------------------------------------------
  // Query setup: upper index and axis weights
  // t = pos + scale/2, upper index = t >> shift, weight_hi = low shift bits
  // ---------------------------------------------------------------------
  logic [SCALE_W-1:0] xscale, yscale, wh_x, wl_x, wh_y, wl_y;
  idx_t               tx, ty, hi_x, hi_y;

  assign xscale = SCALE_W'(1) << x_shift_q;
  assign yscale = SCALE_W'(1) << y_shift_q;
  assign tx     = HI_W'(pos_x_i) + HI_W'(xscale >> 1);
  assign ty     = HI_W'(pos_y_i) + HI_W'(yscale >> 1);
  assign hi_x   = tx >> x_shift_q;
  assign hi_y   = ty >> y_shift_q;
  assign wh_x   = SCALE_W'(tx[SCALE_W-2:0]) & (xscale - 1'b1);
  assign wh_y   = SCALE_W'(ty[SCALE_W-2:0]) & (yscale - 1'b1);
  assign wl_x   = xscale - wh_x;
  assign wl_y   = yscale - wh_y;

  idx_t      hi_x_q, hi_y_q;
  wgt_t      wgt_q [NUM_NB];
  idx_pair_t x_idx_q, y_idx_q;

  // ---------------------------------------------------------------------
  // Shared remainder unit: column first, then row
  // ---------------------------------------------------------------------
  logic  mod_start, mod_done;
  idx_t  mod_dividend;
  size_t mod_divisor, mod_rem;

  assign mod_start    = query_acc || ((state_q == S_MODX) && mod_done);
  assign mod_dividend = (state_q == S_MODX) ? hi_y_q : hi_x;
  assign mod_divisor  = (state_q == S_MODX) ? h_eff : w_eff;

  bufc_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (mod_dividend),
    .divisor_i  (mod_divisor),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  logic [NB_W-1:0] rd_cnt_q, rd_cnt_d, wsel_q, wsel_d;
  logic            rd_pend_q, rd_pend_d;
  logic            out_valid_q, out_valid_d, out_load;

  always_comb begin
    state_d   = state_q;
    rd_cnt_d  = rd_cnt_q;
    wsel_d    = wsel_q;
    rd_pend_d = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (query_acc) state_d = S_MODX;
      end
      S_MODX: begin
        if (mod_done) state_d = S_MODY;
      end
      S_MODY: begin
        if (mod_done) begin
          state_d  = S_RD;
          rd_cnt_d = '0;
        end
      end
      S_RD: begin
        rd_pend_d = 1'b1;
        wsel_d    = rd_cnt_q;
        rd_cnt_d  = rd_cnt_q + 1'b1;
        if (rd_cnt_q == LAST_NB) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        // wait until any earlier result has been taken
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    out_valid_d = out_load | (out_valid_q & out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rd_cnt_q    <= '0;
      wsel_q      <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_cnt_q    <= rd_cnt_d;
      wsel_q      <= wsel_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Operand latches
  always_ff @(posedge clk_i) begin
    if (query_acc) begin
      hi_x_q   <= hi_x;
      hi_y_q   <= hi_y;
      wgt_q[0] <= WGT_W'(wl_x) * WGT_W'(wl_y);
      wgt_q[1] <= WGT_W'(wh_x) * WGT_W'(wl_y);
      wgt_q[2] <= WGT_W'(wl_x) * WGT_W'(wh_y);
      wgt_q[3] <= WGT_W'(wh_x) * WGT_W'(wh_y);
    end
    if ((state_q == S_MODX) && mod_done) begin
      x_idx_q <= axis_idx(hi_x_q, mod_rem, w_eff, edge_mode_q == EDGE_CLAMP);
    end
    if ((state_q == S_MODY) && mod_done) begin
      y_idx_q <= axis_idx(hi_y_q, mod_rem, h_eff, edge_mode_q == EDGE_CLAMP);
    end
  end

  // ---------------------------------------------------------------------
  // Pixel RAM: stores in idle, neighbour reads in S_RD.
  // Read order: (lo,lo) (hi,lo) (lo,hi) (hi,hi) as (column,row),
  // bit 0 of the counter picks the column, bit 1 the row.
  // ---------------------------------------------------------------------
  idx_t  rd_x, rd_y;
  addr_t ram_addr;
  pix_t  ram_rdata;

  assign rd_x     = rd_cnt_q[0] ? x_idx_q.hi : x_idx_q.lo;
  assign rd_y     = rd_cnt_q[1] ? y_idx_q.hi : y_idx_q.lo;
  assign ram_addr = (state_q == S_RD) ? pix_addr(rd_x, rd_y) : st_addr;

  bufc_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (store_acc),
    .addr_i  (ram_addr),
    .wdata_i (st_data),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------
  // Weighted accumulate, one neighbour per cycle
  // ---------------------------------------------------------------------
  mac_ctl_t mac_ctl;
  sum_vec_t acc;

  assign mac_ctl.en    = rd_pend_q;
  assign mac_ctl.first = (wsel_q == '0);

  bufc_mac u_mac (
    .clk_i (clk_i),
    .ctl_i (mac_ctl),
    .pix_i (ram_rdata),
    .wgt_i (wgt_q[wsel_q]),
    .acc_o (acc)
  );

  // ---------------------------------------------------------------------
  // Result register: integer part and dropped low bits per channel
  // ---------------------------------------------------------------------
  logic [SHIFT_W:0]   sh;
  sum_t               frac_mask;
  logic [CH_W-1:0]    int_q  [NUM_CH];
  logic [FRAC_W-1:0]  frac_q [NUM_CH];

  assign sh        = {1'b0, x_shift_q} + {1'b0, y_shift_q};
  assign frac_mask = (SUM_W'(1) << sh) - SUM_W'(1);

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      for (int c = 0; c < NUM_CH; c++) begin
        int_q[c]  <= CH_W'(acc[c] >> sh);
        frac_q[c] <= FRAC_W'(acc[c] & frac_mask);
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign red_out_o    = int_q[0];
  assign green_out_o  = int_q[1];
  assign blue_out_o   = int_q[2];
  assign alpha_out_o  = int_q[3];
  assign red_frac_o   = frac_q[0];
  assign green_frac_o = frac_q[1];
  assign blue_frac_o  = frac_q[2];
  assign alpha_frac_o = frac_q[3];

endmodule

`default_nettype wire

// ----- rtl/core/bufc_checker.sv -----
// bufc_checker: port-level checks on the upscaler core, bound into the core module.
// Depends on bufc_pkg and bilinear_upscale_with_fraction_core_defines.svh.
`default_nettype none
`include "bilinear_upscale_with_fraction_core_defines.svh"

module bufc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic opcode_i,
  input logic out_valid_o,
  input logic out_stall_i
);
  import bufc_pkg::*;

  logic in_beat;

  assign in_beat = in_valid_i && !in_stall_o;

  // reset leaves the block idle with nothing pending
  `BUFC_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !out_valid_o && !in_stall_o, "reset not idle")

  // a query beat occupies the block
  `BUFC_ASSERT(a_query_busy, in_beat && opcode_i == OP_QUERY |=> in_stall_o, "query not stalled")

  // a store beat never yields a result
  `BUFC_ASSERT(a_store_silent, in_beat && opcode_i == OP_STORE && !out_valid_o |=> !out_valid_o, "store result")

  // a stalled result is held
  `BUFC_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o, "stalled result dropped")

endmodule

bind bilinear_upscale_with_fraction_core bufc_checker u_bufc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .opcode_i    (opcode_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i)
);

`default_nettype wire
